/* sv/pft_pkg.sv */
`timescale 1ns / 1ps
package pft_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] GLYPH_FIRST    = 8'd32;
  localparam logic [6:0] GLYPH_FALLBACK = 7'd31;  // '?' minus the first code
  localparam logic [2:0] GLYPH_WIDTH    = 3'd5;
  localparam logic [7:0] BLANK_COLUMN   = 8'h00;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_PIXEL,
    KIND_CHAR,
    KIND_READ,
    KIND_REJECT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] page;
    logic [7:0] column;
    logic [2:0] bit_sel;
    logic       pixel_on;
    logic [6:0] glyph;
    logic       spacing;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       accepted;
  } res_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_RD,
    B_MOD,
    B_CHAR,
    B_RESP
  } bstate_t;

  // Each glyph holds its five columns with the leftmost in the top byte.
  localparam logic [39:0] GLYPH_ROM [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
  };

  function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] k);
    logic [39:0] g;
    g = GLYPH_ROM[idx];
    case (k)
      3'd0:    return g[39:32];
      3'd1:    return g[31:24];
      3'd2:    return g[23:16];
      3'd3:    return g[15:8];
      3'd4:    return g[7:0];
      default: return BLANK_COLUMN;
    endcase
  endfunction

endpackage

/* sv/pft_front.sv */
`timescale 1ns / 1ps
module pft_front import pft_pkg::*; #(
  parameter int DISPLAY_COLUMNS = DEF_COLUMNS,
  parameter int DISPLAY_PAGES   = DEF_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_column,
  input  logic [6:0] in_pixel_row,
  input  logic       in_pixel_on,
  input  logic [3:0] in_page,
  input  logic [7:0] in_char_code,
  input  logic       init_busy,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd;
  logic       push;
  logic       col_ok, row_ok, page_ok, char_fits;

  assign col_ok    = {1'b0, in_column} < 9'(DISPLAY_COLUMNS);
  assign row_ok    = {1'b0, in_pixel_row} < 8'(DISPLAY_PAGES * 8);
  assign page_ok   = {1'b0, in_page} < 5'(DISPLAY_PAGES);
  assign char_fits = ({1'b0, in_column} + 9'd4) < 9'(DISPLAY_COLUMNS);

  always_comb begin
    cmd          = '0;
    cmd.column   = in_column;
    cmd.page     = in_page;
    cmd.bit_sel  = in_pixel_row[2:0];
    cmd.pixel_on = in_pixel_on;
    cmd.spacing  = ({1'b0, in_column} + 9'd5) < 9'(DISPLAY_COLUMNS);
    // Codes below the printable range or with the top bit set fall back to '?'.
    if (in_char_code < GLYPH_FIRST || in_char_code[7]) begin
      cmd.glyph = GLYPH_FALLBACK;
    end else begin
      cmd.glyph = 7'(in_char_code - GLYPH_FIRST);
    end
    case (in_operation)
      OP_CLEAR: cmd.kind = KIND_CLEAR;
      OP_PIXEL: begin
        cmd.page = in_pixel_row[6:3];
        cmd.kind = (col_ok && row_ok) ? KIND_PIXEL : KIND_REJECT;
      end
      OP_CHAR:  cmd.kind = (char_fits && page_ok) ? KIND_CHAR : KIND_REJECT;
      OP_READ:  cmd.kind = (col_ok && page_ok) ? KIND_READ : KIND_REJECT;
      default:  cmd.kind = KIND_REJECT;
    endcase
  end

  assign in_ready = !init_busy && (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

/* sv/pft_back.sv */
`timescale 1ns / 1ps
module pft_back import pft_pkg::*; #(
  parameter int DISPLAY_COLUMNS = DEF_COLUMNS,
  parameter int DISPLAY_PAGES   = DEF_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_accepted
);

  localparam int DEPTH = DISPLAY_PAGES * DISPLAY_COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  bstate_t       state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    k_r, k_nxt;
  res_t          res_r, res_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    mask;

  assign mask = 8'd1 << cmd_r.bit_sel;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = addr_r;
    wdata         = BLANK_COLUMN;
    q_pop         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      B_INIT, B_CLEAR: begin
        we      = 1'b1;
        waddr   = cnt_r;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(DEPTH - 1)) begin
          cnt_nxt = '0;
          if (state_r == B_INIT) begin
            state_nxt = B_IDLE;
          end else begin
            res_nxt   = '{read_data: 8'd0, accepted: 1'b1};
            state_nxt = B_RESP;
          end
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          addr_nxt = AW'(int'(q_cmd.page) * DISPLAY_COLUMNS + int'(q_cmd.column));
          k_nxt    = 3'd0;
          case (q_cmd.kind)
            KIND_CLEAR:             state_nxt = B_CLEAR;
            KIND_PIXEL, KIND_READ:  state_nxt = B_RD;
            KIND_CHAR:              state_nxt = B_CHAR;
            default: begin
              res_nxt   = '{read_data: 8'd0, accepted: 1'b0};
              state_nxt = B_RESP;
            end
          endcase
        end
      end
      B_RD: state_nxt = B_MOD;
      B_MOD: begin
        // Pixel writes are read-modify-write on the byte fetched in the prior cycle.
        if (cmd_r.kind == KIND_PIXEL) begin
          we      = 1'b1;
          wdata   = cmd_r.pixel_on ? (rdata_r | mask) : (rdata_r & ~mask);
          res_nxt = '{read_data: 8'd0, accepted: 1'b1};
        end else begin
          res_nxt = '{read_data: rdata_r, accepted: 1'b1};
        end
        state_nxt = B_RESP;
      end
      B_CHAR: begin
        we    = 1'b1;
        wdata = (k_r == GLYPH_WIDTH) ? BLANK_COLUMN : glyph_byte(cmd_r.glyph, k_r);
        if (k_r == GLYPH_WIDTH || (k_r == GLYPH_WIDTH - 3'd1 && !cmd_r.spacing)) begin
          res_nxt   = '{read_data: 8'd0, accepted: 1'b1};
          state_nxt = B_RESP;
        end else begin
          addr_nxt = addr_r + AW'(1);
          k_nxt    = k_r + 3'd1;
        end
      end
      B_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    addr_r <= addr_nxt;
    k_r    <= k_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[addr_r];
  end

  assign init_busy     = (state_r == B_INIT);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_r.read_data;
  assign out_accepted  = out_r.accepted;

endmodule

/* sv/page_framebuffer_text_engine_unit.sv */
`timescale 1ns / 1ps
// A reject goes straight to its result; pixel and read words pass through the read and
// modify states, a character takes one store write per column, and a clear writes the
// whole store at one byte per cycle. The store sequencer finishes one word before it
// takes the next; a two-word queue lets input run ahead of it.
// Reset is synchronous and active low; afterwards the store is zeroed by a sweep of all
// PAGES*COLUMNS bytes (1024 by default), during which in_ready stays low.
module page_framebuffer_text_engine_unit import pft_pkg::*; #(
  parameter int DISPLAY_COLUMNS = DEF_COLUMNS,
  parameter int DISPLAY_PAGES   = DEF_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_column,
  input  logic [6:0] in_pixel_row,
  input  logic       in_pixel_on,
  input  logic [3:0] in_page,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_accepted
);

  logic q_valid, q_pop, init_busy;
  cmd_t q_cmd;

  pft_front #(
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
    .DISPLAY_PAGES  (DISPLAY_PAGES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_column    (in_column),
    .in_pixel_row (in_pixel_row),
    .in_pixel_on  (in_pixel_on),
    .in_page      (in_page),
    .in_char_code (in_char_code),
    .init_busy    (init_busy),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  pft_back #(
    .DISPLAY_COLUMNS(DISPLAY_COLUMNS),
    .DISPLAY_PAGES  (DISPLAY_PAGES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_accepted  (out_accepted)
  );

endmodule

/* sv/pft_checker.sv */
`timescale 1ns / 1ps
module pft_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_accepted
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_accepted))
    else $error("result word changed while stalled");

  // A rejected operation never returns store data.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_read_data == 8'd0)
    else $error("rejected word carries nonzero data");

  // The store sweep after reset keeps the input closed.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // No result is valid right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind page_framebuffer_text_engine_unit pft_checker u_pft_checker (.*);
